// ----- rtl/b3lut_pkg.sv -----
// shared types, constants and register codes for the binary 3x3 lookup filter
`timescale 1ns / 1ps

package b3lut_pkg;

	localparam int CFG_W          = 10;
	localparam int LIT_W          = 20;
	localparam int WIN_W          = 9;
	localparam int TBL_WORDS      = 8;
	localparam int TBL_WORD_W     = 64;
	localparam int TBL_IDX_W      = 3;
	localparam int TBL_BIT_W      = 6;
	localparam int STORE_W        = 2;
	localparam int MARGIN         = 2;
	localparam int PAD            = 4;
	localparam int WIN_TOP_POS    = 6;
	localparam int WIN_MID_POS    = 3;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;
	localparam int DEF_MAX_WIDTH  = 1020;
	localparam int DEF_MAX_HEIGHT = 1020;

	localparam logic [WIN_W-1:0] WIN_KEEP = 9'h1B6;
	localparam logic [LIT_W-1:0] LIT_MAX  = '1;
	localparam logic [CFG_W-1:0] CFG_RESET = 10'd1;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_TABLE = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic                  pixel;
		logic                  restart_background;
		logic [TBL_IDX_W-1:0]  table_index;
		logic [TBL_WORD_W-1:0] table_word;
	} pix_item_t;

	typedef struct packed {
		logic             out_pixel;
		logic             end_of_row;
		logic             end_of_frame;
		logic [LIT_W-1:0] lit_count;
	} res_item_t;

	typedef struct packed {
		logic v;
		logic emit;
		logic row_end;
		logic frame_end;
		logic first;
	} pix_ctl_t;

endpackage

// ----- rtl/binary_3x3_lut_image_filter.sv -----
// top level of the binary 3x3 lookup-table neighbourhood filter
//
//   channel   direction  handshake              payload
//   pix       in         pix_valid / pix_stall  pix_item (pix_item_t)
//   res       out        res_valid / res_stall  res_item (res_item_t)
//   apb       in         psel / penable         paddr, pwdata, prdata
//
// one item per cycle, pixel or table word, while pix_stall is low; a
// result is registered in the window stage and then in the output register
// the rate is set by the line store ram: one read and one write each cycle
// reset clears the raster position, background, window and lit count; the
// table and line store hold nothing valid until written, no clearing pass
// pix_stall rises only while a pixel waits in the window stage behind a
// stalled result
`timescale 1ns / 1ps

module binary_3x3_lut_image_filter import b3lut_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_item_t             pix_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_item_t             res_item
);

	localparam int DEPTH = MAX_WIDTH + PAD;
	localparam int COL_W = $clog2(DEPTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + PAD);

	logic [CFG_W-1:0]   image_width_q, image_height_q;
	logic               cfg_we, item_acc, pix_acc, tbl_we, s1_ready;
	logic               tbl_bit, tbl_zero, tbl_full;
	logic [COL_W-1:0]   col, st_waddr;
	logic [STORE_W-1:0] st_rdata, st_wdata;
	logic               st_we;
	logic [WIN_W-1:0]   win;
	pix_ctl_t           ctl;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= CFG_RESET;
			image_height_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (paddr[2])
				REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[CFG_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= pwdata[CFG_W-1:0];
				end
				default: begin
					image_width_q <= image_width_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_q);
			default:          prdata = '0;
		endcase
	end

	assign pix_stall = !s1_ready;
	assign item_acc = pix_valid && !pix_stall;
	assign pix_acc = item_acc && (pix_item.mode == MODE_PIXEL);
	assign tbl_we = item_acc && (pix_item.mode == MODE_TABLE);

	b3lut_raster #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.COL_W     (COL_W),
		.ROW_W     (ROW_W)
	) u_raster (
		.clk               (clk),
		.arst_n            (arst_n),
		.acc               (pix_acc),
		.pixel             (pix_item.pixel),
		.restart_background(pix_item.restart_background),
		.image_width       (image_width_q),
		.image_height      (image_height_q),
		.tbl_zero          (tbl_zero),
		.tbl_full          (tbl_full),
		.col               (col),
		.ctl               (ctl)
	);

	b3lut_line_store #(
		.DEPTH(DEPTH),
		.AW   (COL_W)
	) u_line_store (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_en (pix_acc),
		.raddr (col),
		.rdata (st_rdata),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata)
	);

	b3lut_table u_table (
		.clk     (clk),
		.we      (tbl_we),
		.windex  (pix_item.table_index),
		.wword   (pix_item.table_word),
		.idx     (win),
		.bit_out (tbl_bit),
		.bit_zero(tbl_zero),
		.bit_full(tbl_full)
	);

	b3lut_filter #(
		.MAX_WIDTH(MAX_WIDTH),
		.COL_W    (COL_W)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (pix_acc),
		.col      (col),
		.ctl      (ctl),
		.rd_data  (st_rdata),
		.st_we    (st_we),
		.st_waddr (st_waddr),
		.st_wdata (st_wdata),
		.win      (win),
		.tbl_bit  (tbl_bit),
		.s1_ready (s1_ready),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

`ifndef SYNTHESIS
	ap_store_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && st_we |-> col != st_waddr)
		else $error("line store read and write hit the same entry");

	ap_frame_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.end_of_frame |-> res_item.end_of_row)
		else $error("end of frame without end of row");

	ap_lit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.out_pixel |-> res_item.lit_count != '0)
		else $error("lit pixel not counted");

	ap_stall_holds_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> $past(res_valid) || res_valid)
		else $error("input stalled with no result pending");
`endif

endmodule

// ----- rtl/b3lut_raster.sv -----
// raster position, margin selection and background tracking
`timescale 1ns / 1ps

module b3lut_raster import b3lut_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int COL_W      = $clog2(MAX_WIDTH + PAD),
	parameter int ROW_W      = $clog2(MAX_HEIGHT + PAD)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic             pixel,
	input  logic             restart_background,
	input  logic [CFG_W-1:0] image_width,
	input  logic [CFG_W-1:0] image_height,
	input  logic             tbl_zero,
	input  logic             tbl_full,
	output logic [COL_W-1:0] col,
	output pix_ctl_t         ctl
);

	logic [COL_W-1:0] column_count_q, w, last_col, col_c;
	logic [ROW_W-1:0] row_count_q, h, last_row, row_c;
	logic             background_q, bg_eff, first, margin;

	always_comb begin
		w = (int'(image_width) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : COL_W'(image_width);
		h = (int'(image_height) > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT) : ROW_W'(image_height);
		last_col = w + COL_W'(PAD - 1);
		last_row = h + ROW_W'(PAD - 1);
		col_c = (column_count_q > last_col) ? last_col : column_count_q;
		row_c = (row_count_q > last_row) ? last_row : row_count_q;
		first = (col_c == '0) && (row_c == '0);
		bg_eff = background_q & ~(first & restart_background);
		margin = (col_c < COL_W'(MARGIN)) || (col_c >= w + COL_W'(MARGIN)) ||
			(row_c < ROW_W'(MARGIN)) || (row_c >= h + ROW_W'(MARGIN));
		ctl.v = margin ? bg_eff : pixel;
		ctl.emit = (col_c >= COL_W'(MARGIN)) && (row_c >= ROW_W'(MARGIN));
		ctl.row_end = (col_c >= last_col);
		ctl.frame_end = ctl.row_end && (row_c >= last_row);
		ctl.first = first;
		col = col_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q <= '0;
			background_q <= 1'b0;
		end else if (acc) begin
			if (ctl.frame_end) begin
				background_q <= bg_eff ? tbl_full : tbl_zero;
				column_count_q <= '0;
				row_count_q <= '0;
			end else if (ctl.row_end) begin
				background_q <= bg_eff;
				column_count_q <= '0;
				row_count_q <= row_c + ROW_W'(1);
			end else begin
				background_q <= bg_eff;
				column_count_q <= col_c + COL_W'(1);
				row_count_q <= row_c;
			end
		end
	end

endmodule

// ----- rtl/b3lut_line_store.sv -----
// two-row line store, synchronous ram with registered read data
`timescale 1ns / 1ps

module b3lut_line_store import b3lut_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH + PAD,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [AW-1:0]      raddr,
	output logic [STORE_W-1:0] rdata,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [STORE_W-1:0] wdata
);

	logic [STORE_W-1:0] mem [DEPTH];
	logic [STORE_W-1:0] ram_q, fwd_data_q;
	logic               fwd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			ram_q <= mem[raddr];
			fwd_data_q <= wdata;
		end
	end

	// same-entry bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= we && (raddr == waddr);
		end
	end

	assign rdata = fwd_q ? fwd_data_q : ram_q;

endmodule

// ----- rtl/b3lut_table.sv -----
// 512-entry filter table held as eight 64-bit words
`timescale 1ns / 1ps

module b3lut_table import b3lut_pkg::*; (
	input  logic                  clk,
	input  logic                  we,
	input  logic [TBL_IDX_W-1:0]  windex,
	input  logic [TBL_WORD_W-1:0] wword,
	input  logic [WIN_W-1:0]      idx,
	output logic                  bit_out,
	output logic                  bit_zero,
	output logic                  bit_full
);

	logic [TBL_WORD_W-1:0] tbl_q [TBL_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			tbl_q[windex] <= wword;
		end
	end

	assign bit_out  = tbl_q[idx[WIN_W-1 -: TBL_IDX_W]][idx[TBL_BIT_W-1:0]];
	assign bit_zero = tbl_q[0][0];
	assign bit_full = tbl_q[TBL_WORDS-1][TBL_WORD_W-1];

endmodule

// ----- rtl/b3lut_filter.sv -----
// window stage, line store write-back, lit counter and output register
`timescale 1ns / 1ps

module b3lut_filter import b3lut_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(MAX_WIDTH + PAD)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic [COL_W-1:0]   col,
	input  pix_ctl_t           ctl,
	input  logic [STORE_W-1:0] rd_data,
	output logic               st_we,
	output logic [COL_W-1:0]   st_waddr,
	output logic [STORE_W-1:0] st_wdata,
	output logic [WIN_W-1:0]   win,
	input  logic               tbl_bit,
	output logic               s1_ready,
	output logic               res_valid,
	input  logic               res_stall,
	output res_item_t          res_item
);

	logic             valid_s1;
	pix_ctl_t         ctl_s1;
	logic [COL_W-1:0] col_s1;
	logic [WIN_W-1:0] win_q;
	logic [LIT_W-1:0] lit_q, lit_base, lit_next;
	logic             res_valid_q, s2_ready, adv, top, mid;
	res_item_t        res_item_q;

	always_comb begin
		top = rd_data[1];
		mid = rd_data[0];
		win = ((win_q << 1) & WIN_KEEP) | (WIN_W'(top) << WIN_TOP_POS) |
			(WIN_W'(mid) << WIN_MID_POS) | WIN_W'(ctl_s1.v);
		s2_ready = !res_valid_q || !res_stall;
		adv = valid_s1 && s2_ready;
		s1_ready = !valid_s1 || s2_ready;
		lit_base = ctl_s1.first ? '0 : lit_q;
		lit_next = (ctl_s1.emit && tbl_bit && (lit_base != LIT_MAX)) ?
			lit_base + LIT_W'(1) : lit_base;
		st_we = adv;
		st_waddr = col_s1;
		st_wdata = {mid, ctl_s1.v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			win_q <= '0;
			lit_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= acc;
			end
			if (adv) begin
				win_q <= win;
				lit_q <= lit_next;
			end
			if (s2_ready) begin
				res_valid_q <= valid_s1 && ctl_s1.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1 <= ctl;
			col_s1 <= col;
		end
		if (adv && ctl_s1.emit) begin
			res_item_q.out_pixel <= tbl_bit;
			res_item_q.end_of_row <= ctl_s1.row_end;
			res_item_q.end_of_frame <= ctl_s1.frame_end;
			res_item_q.lit_count <= lit_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item = res_item_q;

endmodule
